>>> design/pcpf_pkg.sv
// Shared constants and types of the pitch comb postfilter.
`timescale 1ns / 1ps

package pcpf_pkg;

   localparam int DEF_HISTORY_DEPTH = 1024;
   localparam int DEF_SAMPLE_BITS   = 24;

   localparam int LAG_BITS    = 10;
   localparam int GAIN_BITS   = 16;
   localparam int LAG_MIN     = 15;
   localparam int LAG_MAX_REG = 1022;
   localparam int TAP_COUNT   = 5;
   localparam int TAP_CENTER  = 2;
   localparam int ROUND_SHIFT = 15;
   localparam int ROUND_BIAS  = 1 << (ROUND_SHIFT - 1);

   localparam int CSR_INDEX_BITS = 4;
   localparam int CSR_DATA_BITS  = 16;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PITCH_PERIOD = CSR_INDEX_BITS'(0);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_CENTER  = CSR_INDEX_BITS'(1);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_INNER   = CSR_INDEX_BITS'(2);
   localparam logic [CSR_INDEX_BITS-1:0] CSR_GAIN_OUTER   = CSR_INDEX_BITS'(3);

   localparam logic [LAG_BITS-1:0] PITCH_RESET = LAG_BITS'(LAG_MIN);

   typedef struct packed {
      logic [LAG_BITS-1:0]         lag;
      logic signed [GAIN_BITS-1:0] gain_center;
      logic signed [GAIN_BITS-1:0] gain_inner;
      logic signed [GAIN_BITS-1:0] gain_outer;
   } cfg_type;

   typedef struct packed {
      logic pair;
      logic mult;
      logic round;
      logic out;
   } stage_en_type;

endpackage

>>> design/pcpf_channels.sv
// Handshake channel interfaces of the pitch comb postfilter.
`timescale 1ns / 1ps

interface pcpf_req_if #(parameter int SAMPLE_BITS = pcpf_pkg::DEF_SAMPLE_BITS);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_in;
   logic                          frame_end;
   modport source (output valid, output sample_in, output frame_end, input ready);
   modport sink   (input valid, input sample_in, input frame_end, output ready);
endinterface

interface pcpf_rsp_if #(parameter int SAMPLE_BITS = pcpf_pkg::DEF_SAMPLE_BITS);
   logic                          valid;
   logic                          ready;
   logic signed [SAMPLE_BITS-1:0] sample_out;
   logic                          frame_end_out;
   modport source (output valid, output sample_out, output frame_end_out, input ready);
   modport sink   (input valid, input sample_out, input frame_end_out, output ready);
endinterface

interface pcpf_csr_if;
   logic                                   valid;
   logic                                   ready;
   logic [pcpf_pkg::CSR_INDEX_BITS-1:0]    index;
   logic [pcpf_pkg::CSR_DATA_BITS-1:0]     wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface

>>> design/pcpf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pcpf_ram #(
   parameter int WIDTH = pcpf_pkg::DEF_SAMPLE_BITS,
   parameter int DEPTH = pcpf_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> design/pcpf_csr.sv
// Configuration registers and effective lag clamp.
`timescale 1ns / 1ps

module pcpf_csr #(
   parameter int HISTORY_DEPTH = pcpf_pkg::DEF_HISTORY_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                wr_en,
   input  logic [pcpf_pkg::CSR_INDEX_BITS-1:0] wr_index,
   input  logic [pcpf_pkg::CSR_DATA_BITS-1:0]  wr_data,
   output pcpf_pkg::cfg_type                   cfg
);
   import pcpf_pkg::*;

   localparam int LagMax = (HISTORY_DEPTH - 2) < LAG_MAX_REG ? (HISTORY_DEPTH - 2) : LAG_MAX_REG;
   localparam logic [LAG_BITS-1:0] LagMaxV = LAG_BITS'(LagMax);
   localparam logic [LAG_BITS-1:0] LagMinV = LAG_BITS'(LAG_MIN);

   logic [LAG_BITS-1:0]         pitch_ff, pitch_in;
   logic signed [GAIN_BITS-1:0] g0_ff, g0_in;
   logic signed [GAIN_BITS-1:0] g1_ff, g1_in;
   logic signed [GAIN_BITS-1:0] g2_ff, g2_in;

   always_comb begin
      pitch_in = pitch_ff;
      g0_in    = g0_ff;
      g1_in    = g1_ff;
      g2_in    = g2_ff;
      if (wr_en) begin
         unique case (wr_index)
            CSR_PITCH_PERIOD: pitch_in = wr_data[LAG_BITS-1:0];
            CSR_GAIN_CENTER:  g0_in    = $signed(wr_data[GAIN_BITS-1:0]);
            CSR_GAIN_INNER:   g1_in    = $signed(wr_data[GAIN_BITS-1:0]);
            CSR_GAIN_OUTER:   g2_in    = $signed(wr_data[GAIN_BITS-1:0]);
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= PITCH_RESET;
         g0_ff    <= '0;
         g1_ff    <= '0;
         g2_ff    <= '0;
      end else begin
         pitch_ff <= pitch_in;
         g0_ff    <= g0_in;
         g1_ff    <= g1_in;
         g2_ff    <= g2_in;
      end
   end

   always_comb begin
      priority if (pitch_ff < LagMinV) begin
         cfg.lag = LagMinV;
      end else if (pitch_ff > LagMaxV) begin
         cfg.lag = LagMaxV;
      end else begin
         cfg.lag = pitch_ff;
      end
      cfg.gain_center = g0_ff;
      cfg.gain_inner  = g1_ff;
      cfg.gain_outer  = g2_ff;
   end
endmodule

>>> design/pcpf_tap_fetch.sv
// History store, tap address generation and fill tracking.
`timescale 1ns / 1ps

module pcpf_tap_fetch #(
   parameter int HISTORY_DEPTH = pcpf_pkg::DEF_HISTORY_DEPTH,
   parameter int SAMPLE_BITS   = pcpf_pkg::DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  logic [pcpf_pkg::LAG_BITS-1:0] lag,
   input  logic                          wr_en,
   input  logic signed [SAMPLE_BITS-1:0] wr_data,
   output logic signed [SAMPLE_BITS-1:0] taps [pcpf_pkg::TAP_COUNT]
);
   import pcpf_pkg::*;

   localparam int AW = $clog2(HISTORY_DEPTH);
   localparam int DW = $clog2(HISTORY_DEPTH + 1);
   localparam int PW = DW + 1;
   localparam logic [PW-1:0] DepthP  = PW'(HISTORY_DEPTH);
   localparam logic [DW-1:0] DepthD  = DW'(HISTORY_DEPTH);
   localparam logic [AW-1:0] LastPtr = AW'(HISTORY_DEPTH - 1);

   logic [AW-1:0]        acc_ptr_ff, acc_ptr_in;
   logic [AW-1:0]        wr_ptr_ff, wr_ptr_in;
   logic [DW-1:0]        fill_ff, fill_in;
   logic [TAP_COUNT-1:0] tap_ok_ff, tap_ok_in;
   logic [TAP_COUNT-1:0] tap_ok;
   logic [DW-1:0]        delay [TAP_COUNT];
   logic [AW-1:0]        raddr [TAP_COUNT];
   logic [SAMPLE_BITS-1:0] rdata [TAP_COUNT];

   for (genvar k = 0; k < TAP_COUNT; k++) begin : g_tap
      logic [PW-1:0] base;
      logic [PW-1:0] reach;

      assign delay[k] = DW'(lag) + DW'(k) - DW'(TAP_CENTER);
      assign base     = PW'(acc_ptr_ff);
      assign reach    = PW'(delay[k]);
      assign raddr[k] = (base >= reach) ? AW'(base - reach) : AW'(base + DepthP - reach);
      assign tap_ok[k] = (delay[k] <= fill_ff);

      pcpf_ram #(
         .WIDTH (SAMPLE_BITS),
         .DEPTH (HISTORY_DEPTH)
      ) u_hist (
         .clock (clock),
         .we    (wr_en),
         .waddr (wr_ptr_ff),
         .wdata (wr_data),
         .re    (accept),
         .raddr (raddr[k]),
         .rdata (rdata[k])
      );

      assign taps[k] = tap_ok_ff[k] ? $signed(rdata[k]) : '0;
   end

   always_comb begin
      acc_ptr_in = acc_ptr_ff;
      fill_in    = fill_ff;
      tap_ok_in  = tap_ok_ff;
      wr_ptr_in  = wr_ptr_ff;
      if (accept) begin
         acc_ptr_in = (acc_ptr_ff == LastPtr) ? '0 : acc_ptr_ff + 1'b1;
         fill_in    = (fill_ff == DepthD) ? fill_ff : fill_ff + 1'b1;
         tap_ok_in  = tap_ok;
      end
      if (wr_en) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ptr_ff <= '0;
         wr_ptr_ff  <= '0;
         fill_ff    <= '0;
         tap_ok_ff  <= '0;
      end else begin
         acc_ptr_ff <= acc_ptr_in;
         wr_ptr_ff  <= wr_ptr_in;
         fill_ff    <= fill_in;
         tap_ok_ff  <= tap_ok_in;
      end
   end
endmodule

>>> design/pcpf_mac.sv
// Pair sums, gain products, rounding and saturating sum stages.
`timescale 1ns / 1ps

module pcpf_mac #(
   parameter int SAMPLE_BITS = pcpf_pkg::DEF_SAMPLE_BITS
) (
   input  logic                          clock,
   input  pcpf_pkg::stage_en_type        en,
   input  pcpf_pkg::cfg_type             cfg,
   input  logic signed [SAMPLE_BITS-1:0] taps [pcpf_pkg::TAP_COUNT],
   input  logic signed [SAMPLE_BITS-1:0] x1,
   input  logic                          fe1,
   output logic signed [SAMPLE_BITS-1:0] sat_y,
   output logic signed [SAMPLE_BITS-1:0] y_out,
   output logic                          fe_out
);
   import pcpf_pkg::*;

   localparam int S  = SAMPLE_BITS;
   localparam int PB = S + 17;
   localparam int RB = S + 2;
   localparam int TB = S + 4;
   localparam logic signed [TB-1:0] SatMax = {5'b00000, {(S-1){1'b1}}};
   localparam logic signed [TB-1:0] SatMin = {5'b11111, {(S-1){1'b0}}};
   localparam logic signed [S-1:0]  OutMax = {1'b0, {(S-1){1'b1}}};
   localparam logic signed [S-1:0]  OutMin = {1'b1, {(S-1){1'b0}}};
   localparam logic signed [PB-1:0] Bias   = PB'(ROUND_BIAS);

   logic signed [S-1:0]  x2_ff, x2_in, x3_ff, x3_in, x4_ff, x4_in;
   logic                 fe2_ff, fe2_in, fe3_ff, fe3_in, fe4_ff, fe4_in;
   logic signed [S-1:0]  c2_ff, c2_in;
   logic signed [S:0]    i2_ff, i2_in, o2_ff, o2_in;
   logic signed [PB-1:0] pc3_ff, pc3_in, pi3_ff, pi3_in, po3_ff, po3_in;
   logic signed [PB-1:0] pc_prod, pi_prod, po_prod;
   logic signed [PB-1:0] pc_bias, pi_bias, po_bias;
   logic signed [RB-1:0] rc4_ff, rc4_in, ri4_ff, ri4_in, ro4_ff, ro4_in;
   logic signed [TB-1:0] total;
   logic signed [S-1:0]  y_out_ff, y_out_in;
   logic                 fe_out_ff, fe_out_in;

   assign pc_prod = PB'(c2_ff) * PB'(cfg.gain_center);
   assign pi_prod = PB'(i2_ff) * PB'(cfg.gain_inner);
   assign po_prod = PB'(o2_ff) * PB'(cfg.gain_outer);
   assign pc_bias = pc3_ff + Bias;
   assign pi_bias = pi3_ff + Bias;
   assign po_bias = po3_ff + Bias;
   assign total   = TB'(x4_ff) + TB'(rc4_ff) + TB'(ri4_ff) + TB'(ro4_ff);

   always_comb begin
      priority if (total > SatMax) begin
         sat_y = OutMax;
      end else if (total < SatMin) begin
         sat_y = OutMin;
      end else begin
         sat_y = total[S-1:0];
      end
   end

   always_comb begin
      x2_in  = en.pair ? x1 : x2_ff;
      fe2_in = en.pair ? fe1 : fe2_ff;
      c2_in  = en.pair ? taps[TAP_CENTER] : c2_ff;
      i2_in  = en.pair ? ((S+1)'(taps[TAP_CENTER-1]) + (S+1)'(taps[TAP_CENTER+1])) : i2_ff;
      o2_in  = en.pair ? ((S+1)'(taps[TAP_CENTER-2]) + (S+1)'(taps[TAP_CENTER+2])) : o2_ff;

      x3_in  = en.mult ? x2_ff : x3_ff;
      fe3_in = en.mult ? fe2_ff : fe3_ff;
      pc3_in = en.mult ? pc_prod : pc3_ff;
      pi3_in = en.mult ? pi_prod : pi3_ff;
      po3_in = en.mult ? po_prod : po3_ff;

      x4_in  = en.round ? x3_ff : x4_ff;
      fe4_in = en.round ? fe3_ff : fe4_ff;
      rc4_in = en.round ? pc_bias[PB-1:ROUND_SHIFT] : rc4_ff;
      ri4_in = en.round ? pi_bias[PB-1:ROUND_SHIFT] : ri4_ff;
      ro4_in = en.round ? po_bias[PB-1:ROUND_SHIFT] : ro4_ff;

      y_out_in  = en.out ? sat_y : y_out_ff;
      fe_out_in = en.out ? fe4_ff : fe_out_ff;
   end

   always_ff @(posedge clock) begin
      x2_ff     <= x2_in;
      fe2_ff    <= fe2_in;
      c2_ff     <= c2_in;
      i2_ff     <= i2_in;
      o2_ff     <= o2_in;
      x3_ff     <= x3_in;
      fe3_ff    <= fe3_in;
      pc3_ff    <= pc3_in;
      pi3_ff    <= pi3_in;
      po3_ff    <= po3_in;
      x4_ff     <= x4_in;
      fe4_ff    <= fe4_in;
      rc4_ff    <= rc4_in;
      ri4_ff    <= ri4_in;
      ro4_ff    <= ro4_in;
      y_out_ff  <= y_out_in;
      fe_out_ff <= fe_out_in;
   end

   assign y_out  = y_out_ff;
   assign fe_out = fe_out_ff;
endmodule

>>> design/pitch_comb_postfilter_unit.sv
// Top level of the five-tap recursive pitch comb postfilter.
// Throughput: one request per cycle while the receiver keeps rsp_ch.ready high.
// Each of the five taps has its own history RAM read port.
// Stages: history read, pair sums, gain products, rounding, saturating sum into the output register.
// Reset clears pointers, fill count, valid bits and configuration registers; unwritten history reads as zero.
`timescale 1ns / 1ps

module pitch_comb_postfilter_unit #(
   parameter int HISTORY_DEPTH = pcpf_pkg::DEF_HISTORY_DEPTH,
   parameter int SAMPLE_BITS   = pcpf_pkg::DEF_SAMPLE_BITS
) (
   input  logic        clock,
   input  logic        reset,
   pcpf_req_if.sink    req_ch,
   pcpf_rsp_if.source  rsp_ch,
   pcpf_csr_if.sink    csr_ch
);
   import pcpf_pkg::*;

   cfg_type      cfg;
   stage_en_type en;

   logic v1_ff, v1_in, v2_ff, v2_in, v3_ff, v3_in, v4_ff, v4_in, vo_ff, vo_in;
   logic adv1, adv2, adv3, adv4, advo;
   logic accept;
   logic signed [SAMPLE_BITS-1:0] x1_ff, x1_in;
   logic                          fe1_ff, fe1_in;
   logic signed [SAMPLE_BITS-1:0] taps [TAP_COUNT];
   logic signed [SAMPLE_BITS-1:0] sat_y;

   assign advo = !vo_ff || rsp_ch.ready;
   assign adv4 = !v4_ff || advo;
   assign adv3 = !v3_ff || adv4;
   assign adv2 = !v2_ff || adv3;
   assign adv1 = !v1_ff || adv2;

   assign req_ch.ready = adv1;
   assign accept       = req_ch.valid && adv1;

   assign en.pair  = v1_ff && adv2;
   assign en.mult  = v2_ff && adv3;
   assign en.round = v3_ff && adv4;
   assign en.out   = v4_ff && advo;

   always_comb begin
      v1_in  = accept || (v1_ff && !adv2);
      v2_in  = en.pair || (v2_ff && !adv3);
      v3_in  = en.mult || (v3_ff && !adv4);
      v4_in  = en.round || (v4_ff && !advo);
      vo_in  = en.out || (vo_ff && !rsp_ch.ready);
      x1_in  = accept ? req_ch.sample_in : x1_ff;
      fe1_in = accept ? req_ch.frame_end : fe1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         v1_ff <= v1_in;
         v2_ff <= v2_in;
         v3_ff <= v3_in;
         v4_ff <= v4_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      x1_ff  <= x1_in;
      fe1_ff <= fe1_in;
   end

   assign csr_ch.ready = 1'b1;

   pcpf_csr #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_ch.valid),
      .wr_index (csr_ch.index),
      .wr_data  (csr_ch.wdata),
      .cfg      (cfg)
   );

   pcpf_tap_fetch #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_fetch (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .lag     (cfg.lag),
      .wr_en   (en.out),
      .wr_data (sat_y),
      .taps    (taps)
   );

   pcpf_mac #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_mac (
      .clock  (clock),
      .en     (en),
      .cfg    (cfg),
      .taps   (taps),
      .x1     (x1_ff),
      .fe1    (fe1_ff),
      .sat_y  (sat_y),
      .y_out  (rsp_ch.sample_out),
      .fe_out (rsp_ch.frame_end_out)
   );

   assign rsp_ch.valid = vo_ff;

   a_full_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (vo_ff && !rsp_ch.ready && v1_ff && v2_ff && v3_ff && v4_ff) |-> !req_ch.ready)
      else $error("request taken while pipeline full and stalled");

   a_accept_fills_s1: assert property (@(posedge clock) disable iff (reset)
      accept |=> v1_ff)
      else $error("accepted request lost at first stage");

   a_drain_empties: assert property (@(posedge clock) disable iff (reset)
      (vo_ff && rsp_ch.ready && !v4_ff) |=> !rsp_ch.valid)
      else $error("result repeated after it was taken");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && advo) |=> vo_ff)
      else $error("result lost between rounding and output stage");
endmodule

>>> tb/sv/pcpf_filter_checker.sv
// Output checker: predicts each filtered sample of the pitch comb postfilter and compares.
`timescale 1ns / 1ps

module pcpf_filter_checker #(
   parameter int HISTORY_DEPTH = pcpf_pkg::DEF_HISTORY_DEPTH,
   parameter int SAMPLE_BITS   = pcpf_pkg::DEF_SAMPLE_BITS
) (
   input  logic clock,
   input  logic reset,
   pcpf_req_if  req_mon,
   pcpf_rsp_if  rsp_mon,
   pcpf_csr_if  csr_mon,
   output int   fail_count
);
   import pcpf_pkg::*;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   typedef struct {
      sample_type sample;
      logic       frame_end;
   } filtered_type;

   localparam int LAG_CEIL =
      (HISTORY_DEPTH - 2) < LAG_MAX_REG ? HISTORY_DEPTH - 2 : LAG_MAX_REG;
   localparam longint SAT_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam longint SAT_LO = -SAT_HI - 1;

   sample_type   past_out [HISTORY_DEPTH];
   int unsigned  wr_pos;
   cfg_type      cfg;
   filtered_type expected_outputs [$];
   int           mismatches;

   function automatic longint delayed_out(int unsigned delay);
      return longint'(past_out[(wr_pos + HISTORY_DEPTH - delay) % HISTORY_DEPTH]);
   endfunction

   // floor((p + 2^14) / 2^15): 15 fraction bits of the Q15 gain down to 0
   function automatic longint round_q15(longint prod);
      return (prod + ROUND_BIAS) >>> ROUND_SHIFT;
   endfunction

   function automatic sample_type filter_sample(sample_type x);
      int unsigned lag;
      longint      acc;
      lag = cfg.lag;
      if (lag < LAG_MIN) lag = LAG_MIN;
      if (lag > LAG_CEIL) lag = LAG_CEIL;
      acc = longint'(x)
          + round_q15(delayed_out(lag) * longint'($signed(cfg.gain_center)))
          + round_q15((delayed_out(lag - 1) + delayed_out(lag + 1))
                      * longint'($signed(cfg.gain_inner)))
          + round_q15((delayed_out(lag - 2) + delayed_out(lag + 2))
                      * longint'($signed(cfg.gain_outer)));
      if (acc > SAT_HI) acc = SAT_HI;
      if (acc < SAT_LO) acc = SAT_LO;
      return sample_type'(acc);
   endfunction

   always @(posedge clock) begin
      filtered_type want;
      if (reset) begin
         foreach (past_out[i]) past_out[i] = '0;
         wr_pos = 0;
         cfg = '0;
         cfg.lag = PITCH_RESET;
         expected_outputs.delete();
         mismatches = 0;
      end else begin
         if (csr_mon.valid && csr_mon.ready) begin
            case (csr_mon.index)
               CSR_PITCH_PERIOD: cfg.lag = csr_mon.wdata[LAG_BITS-1:0];
               CSR_GAIN_CENTER:  cfg.gain_center = csr_mon.wdata;
               CSR_GAIN_INNER:   cfg.gain_inner = csr_mon.wdata;
               CSR_GAIN_OUTER:   cfg.gain_outer = csr_mon.wdata;
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_outputs.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected response, expected none, got sample %0d frame_end %0b",
                        $time, rsp_mon.sample_out, rsp_mon.frame_end_out);
            end else begin
               want = expected_outputs.pop_front();
               if (rsp_mon.sample_out !== want.sample) begin
                  mismatches++;
                  $display("%0t: sample_out mismatch, expected %0d, got %0d",
                           $time, want.sample, rsp_mon.sample_out);
               end
               if (rsp_mon.frame_end_out !== want.frame_end) begin
                  mismatches++;
                  $display("%0t: frame_end_out mismatch, expected %0b, got %0b",
                           $time, want.frame_end, rsp_mon.frame_end_out);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            want.sample = filter_sample(req_mon.sample_in);
            want.frame_end = req_mon.frame_end;
            expected_outputs.push_back(want);
            past_out[wr_pos] = want.sample;
            wr_pos = (wr_pos + 1) % HISTORY_DEPTH;
         end
      end
      fail_count = mismatches + expected_outputs.size();
   end

endmodule

>>> tb/sv/pitch_comb_postfilter_unit_tb.sv
// Testbench top of the pitch comb postfilter: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module pitch_comb_postfilter_unit_tb;
   import pcpf_pkg::*;

   localparam int SAMPLE_BITS    = DEF_SAMPLE_BITS;
   localparam int RESULT_LATENCY = 4;
   localparam int RANDOM_PHASES  = 12;
   localparam int PHASE_SAMPLES  = 120;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_MASK, STALL_LONG} stall_kind_type;

   localparam sample_type SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam sample_type CORNER_SAMPLES [8] = '{SAMPLE_MAX, SAMPLE_MIN, sample_type'(0),
      sample_type'(-1), sample_type'(1), sample_type'(24'h555555), sample_type'(24'hAAAAAA),
      sample_type'(24'h800001)};

   localparam logic [CSR_DATA_BITS-1:0] GAIN_MAX  = 16'h7FFF;
   localparam logic [CSR_DATA_BITS-1:0] GAIN_MIN  = 16'h8000;
   localparam logic [CSR_DATA_BITS-1:0] GAIN_ZERO = 16'h0000;

   logic           clock;
   logic           reset;
   int             fail_count;
   int             req_count = 0;
   int             rsp_count = 0;
   stall_kind_type stall_kind = STALL_NONE;
   logic [15:0]    stall_mask = 16'hFFFF;

   pcpf_req_if req_ch ();
   pcpf_rsp_if rsp_ch ();
   pcpf_csr_if csr_ch ();

   pitch_comb_postfilter_unit DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   pcpf_filter_checker output_check (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .csr_mon    (csr_ch),
      .fail_count (fail_count)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   always @(posedge clock) begin
      if (reset) rsp_count <= 0;
      else if (rsp_ch.valid && rsp_ch.ready) rsp_count <= rsp_count + 1;
   end

   // receiver back-pressure
   initial begin
      int   pos;
      int   hold;
      logic long_ready;
      pos = 0;
      hold = 0;
      long_ready = 1'b1;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         case (stall_kind)
            STALL_NONE:   rsp_ch.ready <= 1'b1;
            STALL_RANDOM: rsp_ch.ready <= 1'($urandom_range(0, 1));
            STALL_MASK:   rsp_ch.ready <= stall_mask[pos];
            default: begin
               if (hold == 0) begin
                  long_ready = ~long_ready;
                  hold = long_ready ? $urandom_range(1, 30) : $urandom_range(1, 20);
               end else begin
                  hold--;
               end
               rsp_ch.ready <= long_ready;
            end
         endcase
         pos = (pos + 1) % 16;
      end
   end

   task automatic send_sample(sample_type s, logic fe);
      req_ch.valid     <= 1'b1;
      req_ch.sample_in <= s;
      req_ch.frame_end <= fe;
      do @(posedge clock); while (!req_ch.ready);
      req_count++;
   endtask

   task automatic pause_sender(int cycles);
      req_ch.valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      while (rsp_count != req_count) @(posedge clock);
      repeat (RESULT_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_BITS-1:0] idx, logic [CSR_DATA_BITS-1:0] data);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.wdata <= data;
      do @(posedge clock); while (!csr_ch.ready);
   endtask

   // unused index goes last so a loose decode would clobber a real register
   task automatic configure(logic [CSR_DATA_BITS-1:0] lag_word, logic [CSR_DATA_BITS-1:0] gc,
                            logic [CSR_DATA_BITS-1:0] gi, logic [CSR_DATA_BITS-1:0] go);
      wait_drained();
      write_reg(CSR_PITCH_PERIOD, lag_word);
      write_reg(CSR_GAIN_CENTER, gc);
      write_reg(CSR_GAIN_INNER, gi);
      write_reg(CSR_GAIN_OUTER, go);
      write_reg(CSR_INDEX_BITS'(CSR_GAIN_OUTER + 1 + $urandom_range(0, 11)),
                CSR_DATA_BITS'($urandom));
      csr_ch.valid <= 1'b0;
   endtask

   function automatic sample_type random_sample();
      case ($urandom_range(0, 7))
         0:       return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         1, 2:    return sample_type'($urandom);
         3, 4:    return sample_type'(int'($urandom_range(0, 8191)) - 4096);
         default: return sample_type'(int'($urandom_range(0, 2097151)) - 1048576);
      endcase
   endfunction

   // small gains keep the loop stable, full range mostly saturates
   function automatic logic [CSR_DATA_BITS-1:0] random_gain(bit full_range);
      if (full_range) return CSR_DATA_BITS'($urandom);
      return CSR_DATA_BITS'(int'($urandom_range(0, 8191)) - 4096);
   endfunction

   task automatic stream_random(int n_samples, int gap_pct);
      int burst;
      while (n_samples > 0) begin
         burst = $urandom_range(1, 32);
         for (int i = 0; i < burst && n_samples > 0; i++) begin
            send_sample(random_sample(), $urandom_range(0, 7) == 0);
            n_samples--;
         end
         if ($urandom_range(1, 100) <= gap_pct) pause_sender($urandom_range(1, 6));
      end
   endtask

   initial begin
      reset            <= 1'b1;
      req_ch.valid     <= 1'b0;
      req_ch.sample_in <= '0;
      req_ch.frame_end <= 1'b0;
      csr_ch.valid     <= 1'b0;
      csr_ch.index     <= '0;
      csr_ch.wdata     <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // reset config: pass-through
      foreach (CORNER_SAMPLES[i]) send_sample(CORNER_SAMPLES[i], (i % 2) == 1);

      // lag below range, extreme gains
      configure(16'h0000, GAIN_MAX, GAIN_MIN, GAIN_MAX);
      stall_kind = STALL_RANDOM;
      for (int i = 0; i < 14; i++) send_sample((i % 4) < 2 ? SAMPLE_MAX : SAMPLE_MIN, i == 13);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: configure(16'hFFFF, random_gain(0), random_gain(0), random_gain(0));
            1: configure(16'h0000, GAIN_MAX, GAIN_MIN, GAIN_MAX);
            2: configure(16'd14, GAIN_MIN, GAIN_MIN, GAIN_MIN);
            3: configure(16'd1022, random_gain(0), random_gain(0), random_gain(0));
            4: configure(16'd16, GAIN_ZERO, GAIN_ZERO, GAIN_ZERO);
            5: configure(16'hFC0F, GAIN_MAX, GAIN_MAX, GAIN_MAX);
            default: configure(CSR_DATA_BITS'($urandom), random_gain(p % 2),
                               random_gain(p % 2), random_gain(p % 2));
         endcase
         stall_kind = stall_kind_type'(p % 4);
         stall_mask = 16'($urandom) | 16'h0001;
         stream_random(PHASE_SAMPLES, (p % 3 == 0) ? 0 : 40);
      end

      wait_drained();
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

>>> files.f
design/pcpf_pkg.sv
design/pcpf_channels.sv
design/pcpf_ram.sv
design/pcpf_csr.sv
design/pcpf_tap_fetch.sv
design/pcpf_mac.sv
design/pitch_comb_postfilter_unit.sv
tb/sv/pcpf_filter_checker.sv
tb/sv/pitch_comb_postfilter_unit_tb.sv
